@@ design/jse_pkg.sv @@
// Shared types, constants and helper functions for the JSON string escaper.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

   // Characters that appear in escape sequences
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DEL    = 8'h7F;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_LOWA   = 8'h61;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CTRL_MAX    = 8'h1F;

   // Control bytes with short escapes
   localparam logic [7:0] CTRL_BS = 8'h08;
   localparam logic [7:0] CTRL_HT = 8'h09;
   localparam logic [7:0] CTRL_LF = 8'h0A;
   localparam logic [7:0] CTRL_FF = 8'h0C;
   localparam logic [7:0] CTRL_CR = 8'h0D;

   // Longest escape sequence and the index width that walks it
   localparam int MAX_SEQ   = 6;
   localparam int SEQ_IDX_W = $clog2(MAX_SEQ);

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_SQL_QUOTE_DOUBLE = 2'd0;
   localparam logic [1:0] REG_STRIP_SPACES     = 2'd1;
   localparam logic [1:0] REG_ESCAPE_DEL       = 2'd2;

   typedef enum logic [1:0] {
      KIND_PASS,    // byte as is
      KIND_DOUBLE,  // doubled single quote
      KIND_SHORT,   // backslash + one char held in data
      KIND_UNI      // backslash u 0 0 hex hex of data
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } entry_type;

   typedef struct packed {
      logic sql_quote_double;
      logic strip_spaces;
      logic escape_del;
   } cfg_type;

   // Index of the final byte of a sequence
   function automatic logic [SEQ_IDX_W-1:0] last_idx(input kind_type kind);
      logic [SEQ_IDX_W-1:0] res;
      begin
         unique case (kind)
            KIND_PASS:   res = SEQ_IDX_W'(0);
            KIND_DOUBLE: res = SEQ_IDX_W'(1);
            KIND_SHORT:  res = SEQ_IDX_W'(1);
            KIND_UNI:    res = SEQ_IDX_W'(MAX_SEQ - 1);
            default:     res = SEQ_IDX_W'(0);
         endcase
         return res;
      end
   endfunction

   // Lowercase hex digit of a nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      begin
         if (nib < 4'd10) begin
            return CHAR_ZERO + {4'd0, nib};
         end else begin
            return CHAR_LOWA + {4'd0, nib} - 8'd10;
         end
      end
   endfunction

endpackage

`default_nettype wire

@@ design/jse_front.sv @@
// Front end: classifies one accepted byte into a queue entry or drops it.
// Depends on jse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jse_front (
   input  wire logic              req_valid,
   input  wire logic [7:0]        req_in_byte,
   input  wire logic              queue_full,
   input  wire jse_pkg::cfg_type  cfg,
   output logic                   req_stall,
   output logic                   push,
   output jse_pkg::entry_type     push_entry
);

   logic drop;

   always_comb begin
      req_stall = queue_full;
      drop = cfg.strip_spaces && (req_in_byte == jse_pkg::CHAR_SPACE);
      push = req_valid && !queue_full && !drop;

      push_entry.data = req_in_byte;
      push_entry.kind = jse_pkg::KIND_PASS;
      if (cfg.sql_quote_double && (req_in_byte == jse_pkg::CHAR_SQUOTE)) begin
         push_entry.kind = jse_pkg::KIND_DOUBLE;
      end else begin
         case (req_in_byte)
            jse_pkg::CHAR_DQUOTE: begin
               push_entry.kind = jse_pkg::KIND_SHORT;
               push_entry.data = jse_pkg::CHAR_DQUOTE;
            end
            jse_pkg::CHAR_BSLASH: begin
               push_entry.kind = jse_pkg::KIND_SHORT;
               push_entry.data = jse_pkg::CHAR_BSLASH;
            end
            jse_pkg::CTRL_BS: begin
               push_entry.kind = jse_pkg::KIND_SHORT;
               push_entry.data = jse_pkg::CHAR_B;
            end
            jse_pkg::CTRL_FF: begin
               push_entry.kind = jse_pkg::KIND_SHORT;
               push_entry.data = jse_pkg::CHAR_F;
            end
            jse_pkg::CTRL_LF: begin
               push_entry.kind = jse_pkg::KIND_SHORT;
               push_entry.data = jse_pkg::CHAR_N;
            end
            jse_pkg::CTRL_CR: begin
               push_entry.kind = jse_pkg::KIND_SHORT;
               push_entry.data = jse_pkg::CHAR_R;
            end
            jse_pkg::CTRL_HT: begin
               push_entry.kind = jse_pkg::KIND_SHORT;
               push_entry.data = jse_pkg::CHAR_T;
            end
            default: begin
               if ((req_in_byte <= jse_pkg::CTRL_MAX) ||
                   (cfg.escape_del && (req_in_byte == jse_pkg::CHAR_DEL))) begin
                  push_entry.kind = jse_pkg::KIND_UNI;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ design/jse_queue.sv @@
// Small first-in first-out queue of classified entries between front and back.
// Depends on jse_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module jse_queue #(
   parameter int Depth = jse_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire jse_pkg::entry_type  push_entry,
   input  wire logic                pop,
   output logic                     full,
   output logic                     empty,
   output jse_pkg::entry_type       head
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   jse_pkg::entry_type slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
      begin
         return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
      end
   endfunction

   always_comb begin
      full  = (count_ff == CntW'(Depth));
      empty = (count_ff == '0);
      head  = slots_ff[rd_ptr_ff];

      wr_ptr_in = push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ design/jse_back.sv @@
// Back end: walks the head entry byte by byte into the output register.
// Depends on jse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jse_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                empty,
   input  wire jse_pkg::entry_type  head,
   output logic                     pop,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last_of_run
);

   logic [jse_pkg::SEQ_IDX_W-1:0] idx_ff, idx_in;
   logic                          valid_ff, valid_in;
   logic [7:0]                    byte_ff, byte_in;
   logic                          last_ff, last_in;
   logic                          load;
   logic                          is_last;
   logic [7:0]                    cur_byte;

   always_comb begin
      is_last = (idx_ff == jse_pkg::last_idx(head.kind));

      unique case (head.kind)
         jse_pkg::KIND_PASS:   cur_byte = head.data;
         jse_pkg::KIND_DOUBLE: cur_byte = jse_pkg::CHAR_SQUOTE;
         jse_pkg::KIND_SHORT:  cur_byte = (idx_ff == '0) ? jse_pkg::CHAR_BSLASH : head.data;
         jse_pkg::KIND_UNI: begin
            case (idx_ff)
               3'd0:    cur_byte = jse_pkg::CHAR_BSLASH;
               3'd1:    cur_byte = jse_pkg::CHAR_U;
               3'd4:    cur_byte = jse_pkg::hex_digit(head.data[7:4]);
               3'd5:    cur_byte = jse_pkg::hex_digit(head.data[3:0]);
               default: cur_byte = jse_pkg::CHAR_ZERO;
            endcase
         end
         default: cur_byte = head.data;
      endcase

      // Load the output register when an entry waits and the register is free or being drained this cycle
      load = !empty && (!valid_ff || !rsp_stall);
      pop  = load && is_last;

      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         idx_in   = is_last ? '0 : idx_ff + jse_pkg::SEQ_IDX_W'(1);
         valid_in = 1'b1;
         byte_in  = cur_byte;
         last_in  = is_last;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

@@ design/json_string_escaper.sv @@
// Top level of the JSON string escaper: register file, front, queue and back.
// Depends on jse_pkg, jse_front, jse_queue and jse_back.
//
// Escapes a byte stream for use inside a JSON string. Each beat accepted on
// the req_ channel is one raw byte; the rsp_ channel returns its escaped form
// one byte per beat, with rsp_last_of_run marking the final byte of each run.
// Quote and backslash become a backslash pair, backspace, form feed, newline,
// return and tab become short escapes, other control bytes and (optionally)
// DEL become a six-byte \u00xx escape with lowercase hex, and bytes 0x80-0xFF
// pass unchanged. With strip_spaces set a space yields no beat at all; with
// sql_quote_double set a single quote yields two. Rate, while rsp_stall is
// low: the back end issues one output byte per cycle, so an n-byte escape
// (1, 2 or 6) leaves as n consecutive bytes and plain bytes stream at one
// per cycle. A queue of QueueDepth entries lets the input keep accepting
// while an escape drains; req_stall rises only when that queue is full.
// Each byte is queued, then registered at the output. Configuration registers
// sit at byte addresses 0, 4 and 8 (sql_quote_double, strip_spaces,
// escape_del, bit 0 of each); write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module json_string_escaper #(
   parameter int QueueDepth = jse_pkg::QUEUE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_in_byte,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [7:0]                           rsp_out_byte,
   output logic                                 rsp_last_of_run,
   // configuration port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [jse_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [jse_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [jse_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);

   jse_pkg::cfg_type   cfg_ff, cfg_in;
   logic               cfg_write;
   logic [1:0]         reg_idx;
   logic               push, pop, queue_full, queue_empty;
   jse_pkg::entry_type push_entry, head;

   // ---------------------------------------------------------------------
   // Register file: the write lands on the access cycle, reads are combinational
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign reg_idx   = paddr[3:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (reg_idx)
         jse_pkg::REG_SQL_QUOTE_DOUBLE: begin
            prdata[0] = cfg_ff.sql_quote_double;
            if (cfg_write) begin
               cfg_in.sql_quote_double = pwdata[0];
            end
         end
         jse_pkg::REG_STRIP_SPACES: begin
            prdata[0] = cfg_ff.strip_spaces;
            if (cfg_write) begin
               cfg_in.strip_spaces = pwdata[0];
            end
         end
         jse_pkg::REG_ESCAPE_DEL: begin
            prdata[0] = cfg_ff.escape_del;
            if (cfg_write) begin
               cfg_in.escape_del = pwdata[0];
            end
         end
         default: begin
            // no register here: drop the write, read back zero
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sql_quote_double <= 1'b0;
         cfg_ff.strip_spaces     <= 1'b0;
         cfg_ff.escape_del       <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Front: classify each accepted beat, drop stripped spaces
   // ---------------------------------------------------------------------
   jse_front u_front (
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .queue_full  (queue_full),
      .cfg         (cfg_ff),
      .req_stall   (req_stall),
      .push        (push),
      .push_entry  (push_entry)
   );

   // ---------------------------------------------------------------------
   // Queue: hold classified entries while the back end expands an escape
   // ---------------------------------------------------------------------
   jse_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   // ---------------------------------------------------------------------
   // Back: while rsp_stall is low, advance through the head entry one output byte per cycle
   // ---------------------------------------------------------------------
   jse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (queue_empty),
      .head            (head),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

@@ design/jse_checker.sv @@
// Port-level checks for json_string_escaper, attached by the bind at the end.
// Depends on jse_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module jse_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_of_run,
   input wire logic       pready
);

   // A stalled result beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
                                 && $stable(rsp_last_of_run))
      else $error("stalled result beat changed");

   // Nothing comes out on the first cycle after reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result beat valid right after reset");

   // Only escape bytes can be followed by more of the same run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |->
         (rsp_out_byte == jse_pkg::CHAR_BSLASH) ||
         (rsp_out_byte == jse_pkg::CHAR_U) ||
         (rsp_out_byte == jse_pkg::CHAR_ZERO) ||
         (rsp_out_byte == jse_pkg::hex_digit(4'h1)) ||
         (rsp_out_byte == jse_pkg::hex_digit(4'h7)) ||
         (rsp_out_byte == jse_pkg::CHAR_SQUOTE))
      else $error("unexpected byte inside an escape run");

   // Configuration port never waits
   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind json_string_escaper jse_checker u_jse_checker (.*);

`default_nettype wire

@@ tb/json_string_escaper_test.sv @@
// Self-checking testbench for the JSON string escaper (json_string_escaper).
// Depends on jse_pkg and the design files; predicts every output byte in place.
// Covers directed escape cases, register modes and long random text runs.
`timescale 1ns / 1ps
`default_nettype none

module json_string_escaper_test;

   // Run bounds
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 31;
   localparam int REPORT_LIMIT  = 10;

   // Register index that decodes to nothing; writes there must be dropped
   localparam logic [1:0] REG_UNMAPPED = 2'd3;

   // One predicted output beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } esc_beat_type;

   // DUT-facing signals; the ones the bench drives are known from time zero
   logic                           clock           = 1'b0;
   logic                           reset           = 1'b1;
   logic                           req_valid       = 1'b0;
   logic                           req_stall;
   logic [7:0]                     req_in_byte     = 8'h00;
   logic                           rsp_valid;
   logic                           rsp_stall       = 1'b0;
   logic [7:0]                     rsp_out_byte;
   logic                           rsp_last_of_run;
   logic                           psel            = 1'b0;
   logic                           penable         = 1'b0;
   logic                           pwrite          = 1'b0;
   logic [jse_pkg::CSR_ADDR_W-1:0] paddr           = '0;
   logic [jse_pkg::CSR_DATA_W-1:0] pwdata          = '0;
   logic [jse_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   // Mirror of the mode registers, at their reset values
   logic mode_sql   = 1'b0;
   logic mode_strip = 1'b0;
   logic mode_del   = 1'b1;

   // Escaped bytes still owed by the block, oldest first
   esc_beat_type pending_bytes[$];

   // Bookkeeping
   int    mismatch_cnt = 0;
   int    bytes_sent   = 0;
   int    beats_seen   = 0;
   int    reg_writes   = 0;
   int    stall_hold   = 0;
   bit    quiet        = 1'b0;   // when set, no new gaps or stalls are started
   string hex_lower    = "0123456789abcdef";

   json_string_escaper u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog: end the run if it never drains
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Count a failure; print only the first few in full
   function automatic void flag_mismatch(input string what);
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_LIMIT) begin
         $display("mismatch @%0t: %s", $time, what);
      end
   endfunction

   // Predict the escaped form of one accepted byte and queue it.
   // A dropped space queues nothing.
   function automatic void escape_byte(input logic [7:0] b);
      logic [7:0]   seq[$];
      esc_beat_type beat;
      if (b == jse_pkg::CHAR_SPACE && mode_strip) begin
         return;
      end
      if (b == jse_pkg::CHAR_SQUOTE && mode_sql) begin
         seq = '{jse_pkg::CHAR_SQUOTE, jse_pkg::CHAR_SQUOTE};
      end else begin
         case (b)
            jse_pkg::CHAR_DQUOTE: seq = '{jse_pkg::CHAR_BSLASH, jse_pkg::CHAR_DQUOTE};
            jse_pkg::CHAR_BSLASH: seq = '{jse_pkg::CHAR_BSLASH, jse_pkg::CHAR_BSLASH};
            jse_pkg::CTRL_BS:     seq = '{jse_pkg::CHAR_BSLASH, jse_pkg::CHAR_B};
            jse_pkg::CTRL_FF:     seq = '{jse_pkg::CHAR_BSLASH, jse_pkg::CHAR_F};
            jse_pkg::CTRL_LF:     seq = '{jse_pkg::CHAR_BSLASH, jse_pkg::CHAR_N};
            jse_pkg::CTRL_CR:     seq = '{jse_pkg::CHAR_BSLASH, jse_pkg::CHAR_R};
            jse_pkg::CTRL_HT:     seq = '{jse_pkg::CHAR_BSLASH, jse_pkg::CHAR_T};
            default: begin
               // Remaining control bytes, and DEL when enabled, take the long form
               if (b <= jse_pkg::CTRL_MAX || (b == jse_pkg::CHAR_DEL && mode_del)) begin
                  seq = '{jse_pkg::CHAR_BSLASH, jse_pkg::CHAR_U,
                          jse_pkg::CHAR_ZERO, jse_pkg::CHAR_ZERO,
                          hex_lower[int'(b[7:4])], hex_lower[int'(b[3:0])]};
               end else begin
                  seq = '{b};
               end
            end
         endcase
      end
      foreach (seq[i]) begin
         beat.out_byte    = seq[i];
         beat.last_of_run = (i == seq.size() - 1);
         pending_bytes    = {pending_bytes, beat};
      end
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 30);
   endfunction

   // Result side back-pressure. Hold each choice for a random run of cycles;
   // while quiet is set, drop it once any running hold ends.
   always @(posedge clock) begin : drive_rsp_stall
      int roll;
      if (stall_hold != 0) begin
         stall_hold--;
      end else if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            rsp_stall  <= 1'b0;
            stall_hold = $urandom_range(0, 7);
         end else if (roll < 92) begin
            rsp_stall  <= 1'b1;
            stall_hold = $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_hold = $urandom_range(9, 24);
         end
      end
   end

   // Compare every accepted output beat with the oldest prediction
   always @(posedge clock) begin : check_rsp
      esc_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (pending_bytes.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat byte=%02h last=%0b",
                                    rsp_out_byte, rsp_last_of_run));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               flag_mismatch($sformatf("out_byte expected %02h got %02h",
                                       want.out_byte, rsp_out_byte));
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               flag_mismatch($sformatf("last_of_run expected %0b got %0b (byte %02h)",
                                       want.last_of_run, rsp_last_of_run, want.out_byte));
            end
         end
      end
   end

   // Send one input beat. Valid stays high across back-to-back beats;
   // lower it only when a gap is inserted.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Beat counted as taken once req_stall reads low after an edge
      escape_byte(b);
      bytes_sent++;
   endtask

   // Drop valid, drain all owed beats, then let the block settle
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Two-phase register write; junk in the upper bits must be ignored
   task automatic write_reg(input logic [1:0] idx, input logic bit_val);
      logic [jse_pkg::CSR_DATA_W-1:0] word;
      word    = $urandom;
      word[0] = bit_val;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         jse_pkg::REG_SQL_QUOTE_DOUBLE: mode_sql   = bit_val;
         jse_pkg::REG_STRIP_SPACES:     mode_strip = bit_val;
         jse_pkg::REG_ESCAPE_DEL:       mode_del   = bit_val;
         default: ;
      endcase
      reg_writes++;
   endtask

   // Drain, then load all three modes plus a write to the hole in the map
   task automatic apply_modes(input logic sql, input logic strip, input logic del);
      settle();
      write_reg(jse_pkg::REG_SQL_QUOTE_DOUBLE, sql);
      write_reg(REG_UNMAPPED, 1'($urandom_range(0, 1)));
      write_reg(jse_pkg::REG_STRIP_SPACES, strip);
      write_reg(jse_pkg::REG_ESCAPE_DEL, del);
   endtask

   // Random text byte, weighted toward the interesting classes
   function automatic logic [7:0] pick_text_byte();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0, 1, 2, 3: return 8'($urandom_range(8'h21, 8'h7E));
         4: begin
            case ($urandom_range(0, 4))
               0:       return jse_pkg::CHAR_SPACE;
               1:       return jse_pkg::CHAR_SQUOTE;
               2:       return jse_pkg::CHAR_DQUOTE;
               3:       return jse_pkg::CHAR_BSLASH;
               default: return jse_pkg::CHAR_DEL;
            endcase
         end
         5, 6: return 8'($urandom_range(8'h00, jse_pkg::CTRL_MAX));
         7:    return 8'($urandom_range(8'h80, 8'hFF));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Reset modes: every escape class, both field extremes, hex letters
   task automatic test_escape_table();
      logic [7:0] probe[$];
      probe = '{8'h00, jse_pkg::CTRL_BS, jse_pkg::CTRL_HT, jse_pkg::CTRL_LF, 8'h0B,
                jse_pkg::CTRL_FF, jse_pkg::CTRL_CR, 8'h1A, jse_pkg::CTRL_MAX,
                jse_pkg::CHAR_DQUOTE, jse_pkg::CHAR_BSLASH, jse_pkg::CHAR_DEL,
                jse_pkg::CHAR_SPACE, jse_pkg::CHAR_SQUOTE, 8'h41, 8'h80, 8'hFF};
      foreach (probe[i]) send_byte(probe[i]);
   endtask

   // Flip every mode: doubled quote, dropped spaces (two in a row), plain DEL
   task automatic test_modes_flipped();
      logic [7:0] probe[$];
      probe = '{jse_pkg::CHAR_SQUOTE, jse_pkg::CHAR_SPACE, jse_pkg::CHAR_SPACE,
                jse_pkg::CHAR_DEL, jse_pkg::CHAR_DQUOTE, 8'h1C, 8'hFF};
      apply_modes(1'b1, 1'b1, 1'b0);
      foreach (probe[i]) send_byte(probe[i]);
   endtask

   // Random text under a sweep of mode settings, one phase without idling
   task automatic test_random_text();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_modes(1'b0, 1'b0, 1'b1);
            1: apply_modes(1'b1, 1'b1, 1'b1);
            2: apply_modes(1'b0, 1'b0, 1'b0);
            3: apply_modes(1'b1, 1'b0, 1'b0);
            4: apply_modes(1'b0, 1'b1, 1'b1);
            default: apply_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
         endcase
         quiet = (phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_byte(pick_text_byte());
         end
         quiet = 1'b0;
      end
   endtask

   // Sequence the run
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_escape_table();
      test_modes_flipped();
      test_random_text();
      settle();
      $display("Escaped %0d input bytes into %0d output beats across %0d register writes,",
               bytes_sent, beats_seen, reg_writes);
      $display("sweeping quote doubling, space dropping and DEL escaping on and off.");
      if (mismatch_cnt == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches in total", mismatch_cnt);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
